FILE: hdl/dlb_pkg.sv
package dlb_pkg;

  // Widest sample the block handles; narrower samples sit in the low bits
  localparam int MAX_SAMPLE_BITS = 16;
  localparam int MIN_SAMPLE_BITS = 8;

  // Register stages from the input register to the output register
  localparam int STAGES = 9;

  // Configuration register indexes
  localparam logic [1:0] CFG_DARKEN_MODE = 2'd0;
  localparam logic [1:0] CFG_PIXEL_BITS  = 2'd1;
  localparam logic [1:0] CFG_USE_MASK    = 2'd2;
  localparam logic [1:0] CFG_OPACITY     = 2'd3;

  // Input beat
  typedef struct packed {
    logic [15:0] base_luma;
    logic [15:0] base_cb;
    logic [15:0] base_cr;
    logic [15:0] over_luma;
    logic [15:0] over_cb;
    logic [15:0] over_cr;
    logic [15:0] mask_luma;
    logic [15:0] mask_cb;
    logic [15:0] mask_cr;
  } dlb_in_t;

  // Result beat
  typedef struct packed {
    logic [15:0] out_luma;
    logic [15:0] out_cb;
    logic [15:0] out_cr;
  } dlb_out_t;

  // Decoded configuration shared by the lanes
  typedef struct packed {
    logic [4:0]  nbits;     // sample width, clamped to 8..16
    logic [15:0] maxv;      // 2^nbits - 1
    logic [14:0] rnd;       // maxv / 2
    logic [15:0] op;        // opacity clamped to maxv
    logic        full;      // op == maxv
    logic        use_mask;
  } dlb_ctl_t;

  // Clamp a sample to the current max value
  function automatic logic [15:0] dlb_sat(input logic [15:0] v, input logic [15:0] maxv);
    logic [15:0] r;
    r = (v > maxv) ? maxv : v;
    return r;
  endfunction

endpackage

FILE: hdl/dlb_mdiv.sv
// Two-stage divide by (2^n - 1) for dividends below 2^(2n).
// Stage A: quotient estimate (x + x>>n) >> n, low by at most one, plus remainder.
// Stage B: compare-subtract correction.
module dlb_mdiv import dlb_pkg::*; (
  input  logic        clk,
  input  logic        en_a,
  input  logic        en_b,
  input  logic [4:0]  nbits,
  input  logic [15:0] maxv,
  input  logic [31:0] x,
  output logic [15:0] q
);

  logic [32:0] sum_w;
  logic [32:0] est_w;
  logic [32:0] mul_w;
  logic [32:0] rem_w;

  logic [16:0] est_r;
  logic [17:0] rem_r;
  logic [15:0] q_r;

  logic [17:0] rem1;
  logic [16:0] est1;
  logic [16:0] est2;

  // Estimate and remainder
  always_comb begin
    sum_w = {1'b0, x} + ({1'b0, x} >> nbits);
    est_w = sum_w >> nbits;
    mul_w = (est_w << nbits) - est_w;
    rem_w = {1'b0, x} - mul_w;
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      est_r <= est_w[16:0];
      rem_r <= rem_w[17:0];
    end
  end

  // Correction, two steps for margin
  always_comb begin
    rem1 = rem_r;
    est1 = est_r;
    if (rem_r >= {2'b00, maxv}) begin
      rem1 = rem_r - {2'b00, maxv};
      est1 = est_r + 17'd1;
    end
    est2 = est1;
    if (rem1 >= {2'b00, maxv}) begin
      est2 = est1 + 17'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      q_r <= est2[15:0];
    end
  end

  assign q = q_r;

endmodule

FILE: hdl/dlb_lane.sv
// One color channel: weight, divide, mix, divide, select.
// stg_en[k] loads pipeline stage k+1.
module dlb_lane import dlb_pkg::*; (
  input  logic        clk,
  input  logic [7:0]  stg_en,
  input  dlb_ctl_t    ctl,
  input  logic [15:0] b_in,
  input  logic [15:0] o_in,
  input  logic [15:0] m_in,
  input  logic        act_in,
  output logic [15:0] res
);

  logic [15:0] b1_r, o1_r, m1_r;
  logic        a1_r;
  logic [31:0] p1_r;
  logic [15:0] b2_r, o2_r, m2_r;
  logic        a2_r;
  logic [15:0] b3_r, o3_r, m3_r;
  logic        a3_r;
  logic [15:0] q_eff;
  logic [15:0] eff;
  logic [31:0] pa4_r, pb4_r;
  logic [15:0] b4_r;
  logic        a4_r;
  logic [31:0] s5_r;
  logic [15:0] b5_r, b6_r, b7_r;
  logic        a5_r, a6_r, a7_r;
  logic [15:0] q_mix;
  logic [15:0] r8_r;
  logic [15:0] rnd_mix;

  // Stage 1: mask times opacity plus rounder
  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      p1_r <= (32'(m_in) * 32'(ctl.op)) + 32'(ctl.rnd);
      b1_r <= b_in;
      o1_r <= o_in;
      m1_r <= m_in;
      a1_r <= act_in;
    end
  end

  // Stages 2-3: effective weight divide
  dlb_mdiv u_div_eff (
    .clk   (clk),
    .en_a  (stg_en[1]),
    .en_b  (stg_en[2]),
    .nbits (ctl.nbits),
    .maxv  (ctl.maxv),
    .x     (p1_r),
    .q     (q_eff)
  );

  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      b2_r <= b1_r;
      o2_r <= o1_r;
      m2_r <= m1_r;
      a2_r <= a1_r;
    end
    if (stg_en[2]) begin
      b3_r <= b2_r;
      o3_r <= o2_r;
      m3_r <= m2_r;
      a3_r <= a2_r;
    end
  end

  // Weight select: full opacity with no mask uses maxv, which copies the overlay
  always_comb begin
    if (ctl.full) begin
      eff = ctl.use_mask ? m3_r : ctl.maxv;
    end else begin
      eff = ctl.use_mask ? q_eff : ctl.op;
    end
  end

  // Stage 4: the two weighted products
  always_ff @(posedge clk) begin
    if (stg_en[3]) begin
      pa4_r <= 32'(ctl.maxv - eff) * 32'(b3_r);
      pb4_r <= 32'(eff) * 32'(o3_r);
      b4_r  <= b3_r;
      a4_r  <= a3_r;
    end
  end

  // Stage 5: sum plus rounder (no rounder at full opacity)
  assign rnd_mix = ctl.full ? 16'd0 : {1'b0, ctl.rnd};

  always_ff @(posedge clk) begin
    if (stg_en[4]) begin
      s5_r <= pa4_r + pb4_r + 32'(rnd_mix);
      b5_r <= b4_r;
      a5_r <= a4_r;
    end
  end

  // Stages 6-7: mix divide
  dlb_mdiv u_div_mix (
    .clk   (clk),
    .en_a  (stg_en[5]),
    .en_b  (stg_en[6]),
    .nbits (ctl.nbits),
    .maxv  (ctl.maxv),
    .x     (s5_r),
    .q     (q_mix)
  );

  always_ff @(posedge clk) begin
    if (stg_en[5]) begin
      b6_r <= b5_r;
      a6_r <= a5_r;
    end
    if (stg_en[6]) begin
      b7_r <= b6_r;
      a7_r <= a6_r;
    end
  end

  // Stage 8: blended value or base pass-through
  always_ff @(posedge clk) begin
    if (stg_en[7]) begin
      r8_r <= a7_r ? q_mix : b7_r;
    end
  end

  assign res = r8_r;

endmodule

FILE: hdl/darken_lighten_masked_blend_top.sv
// Channel  Ports                          Width   Handshake
// in       in_valid/in_ready/in_data      144     valid/ready beat
// out      out_valid/out_ready/out_data   48      valid/ready beat
// cfg      cfg_we/cfg_index/cfg_data      2+16    write on cfg_we, no wait
//
// Nine register stages, input register to output register; one beat per cycle sustained
// while out_ready stays high; the two multiply/divide passes per lane set the depth.
// Each stage loads when empty or when the stage ahead moves, so bubbles close up
// and a stall at out_ready backs up stage by stage without losing or repeating beats.
// rst_n (synchronous, active low) empties the pipe and loads the register defaults.
module darken_lighten_masked_blend_top import dlb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  dlb_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output dlb_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic        darken_r;
  logic [4:0]  bits_r;
  logic        use_mask_r;
  logic [15:0] opacity_r;

  dlb_ctl_t    ctl;
  logic [STAGES-1:0] v_r;
  logic [STAGES:0]   en;

  logic [15:0] b0_r [3];
  logic [15:0] o0_r [3];
  logic [15:0] m0_r [3];
  logic        act0_r;
  logic        act_nxt;
  logic [15:0] res [3];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      darken_r   <= 1'b1;
      bits_r     <= 5'd8;
      use_mask_r <= 1'b0;
      opacity_r  <= 16'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DARKEN_MODE: darken_r   <= cfg_data[0];
        CFG_PIXEL_BITS:  bits_r     <= cfg_data[4:0];
        CFG_USE_MASK:    use_mask_r <= cfg_data[0];
        CFG_OPACITY:     opacity_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decoded controls
  always_comb begin
    logic [16:0] m17;
    if (bits_r < 5'(MIN_SAMPLE_BITS)) begin
      ctl.nbits = 5'(MIN_SAMPLE_BITS);
    end else if (bits_r > 5'(MAX_SAMPLE_BITS)) begin
      ctl.nbits = 5'(MAX_SAMPLE_BITS);
    end else begin
      ctl.nbits = bits_r;
    end
    m17          = (17'd1 << ctl.nbits) - 17'd1;
    ctl.maxv     = m17[15:0];
    ctl.rnd      = ctl.maxv[15:1];
    ctl.op       = dlb_sat(opacity_r, ctl.maxv);
    ctl.full     = (ctl.op == ctl.maxv);
    ctl.use_mask = use_mask_r;
  end

  // Stage enables: a stage loads when empty or when the next one moves
  always_comb begin
    en[STAGES] = out_ready;
    for (int i = STAGES - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[STAGES-1];

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // Stage 0: clamp samples, decide whether the blend applies
  always_comb begin
    logic [15:0] bl;
    logic [15:0] ol;
    bl = dlb_sat(in_data.base_luma, ctl.maxv);
    ol = dlb_sat(in_data.over_luma, ctl.maxv);
    act_nxt = darken_r ? (ol < bl) : (ol > bl);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      b0_r[0] <= dlb_sat(in_data.base_luma, ctl.maxv);
      b0_r[1] <= dlb_sat(in_data.base_cb,   ctl.maxv);
      b0_r[2] <= dlb_sat(in_data.base_cr,   ctl.maxv);
      o0_r[0] <= dlb_sat(in_data.over_luma, ctl.maxv);
      o0_r[1] <= dlb_sat(in_data.over_cb,   ctl.maxv);
      o0_r[2] <= dlb_sat(in_data.over_cr,   ctl.maxv);
      m0_r[0] <= dlb_sat(in_data.mask_luma, ctl.maxv);
      m0_r[1] <= dlb_sat(in_data.mask_cb,   ctl.maxv);
      m0_r[2] <= dlb_sat(in_data.mask_cr,   ctl.maxv);
      act0_r  <= act_nxt;
    end
  end

  // Three channel lanes
  for (genvar c = 0; c < 3; c++) begin : g_lane
    dlb_lane u_lane (
      .clk    (clk),
      .stg_en (en[STAGES-1:1]),
      .ctl    (ctl),
      .b_in   (b0_r[c]),
      .o_in   (o0_r[c]),
      .m_in   (m0_r[c]),
      .act_in (act0_r),
      .res    (res[c])
    );
  end

  assign out_data.out_luma = res[0];
  assign out_data.out_cb   = res[1];
  assign out_data.out_cr   = res[2];

  // An empty output register always lets a beat in
  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output register");

  // A full pipe under output stall takes nothing
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r && !out_ready) |-> !in_ready)
    else $error("input accepted into a full stalled pipe");

  // A beat entering an empty pipe reaches the output after the full latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r == '0 && in_valid && in_ready) |-> ##9 out_valid)
    else $error("beat lost in empty pipe");

endmodule
